// ===== hw/rtl/hfr_pkg.sv =====
// Package for the frame receiver: parse stages, status codes, delimiter masks,
// queue entry and configuration types.
// No dependencies.
package hfr_pkg;

    localparam int LONG_ADDR_BYTES = 5;
    localparam int UADDR_W         = 8 * (LONG_ADDR_BYTES - 1) + 6;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [3:0] {
        STG_PRE   = 4'd0,
        STG_START = 4'd1,
        STG_DELIM = 4'd2,
        STG_ADDR  = 4'd3,
        STG_CMD   = 4'd4,
        STG_COUNT = 4'd5,
        STG_DATA  = 4'd6,
        STG_CHECK = 4'd7,
        STG_DRAIN = 4'd8
    } hfr_stage_t;

    localparam logic [3:0] STS_OK          = 4'd0;
    localparam logic [3:0] STS_PRE_SHORT   = 4'd1;
    localparam logic [3:0] STS_PRE_VALUE   = 4'd2;
    localparam logic [3:0] STS_START_SHORT = 4'd3;
    localparam logic [3:0] STS_START_VALUE = 4'd4;
    localparam logic [3:0] STS_NO_DELIM    = 4'd5;
    localparam logic [3:0] STS_EXPANSION   = 4'd6;
    localparam logic [3:0] STS_NOT_FSK     = 4'd7;
    localparam logic [3:0] STS_SADDR_SHORT = 4'd8;
    localparam logic [3:0] STS_LADDR_SHORT = 4'd9;
    localparam logic [3:0] STS_ADDR_MISM   = 4'd10;
    localparam logic [3:0] STS_NO_CMD      = 4'd11;
    localparam logic [3:0] STS_NO_COUNT    = 4'd12;
    localparam logic [3:0] STS_DATA_SHORT  = 4'd13;
    localparam logic [3:0] STS_NO_CHECK    = 4'd14;
    localparam logic [3:0] STS_BAD_CHECK   = 4'd15;

    localparam logic [7:0] SYNC_BYTE      = 8'hFF;
    localparam logic [7:0] DELIM_EXP_MASK = 8'h60;
    localparam logic [7:0] DELIM_MOD_MASK = 8'h18;
    localparam logic [7:0] DELIM_TYP_MASK = 8'h07;
    localparam int         DELIM_LONG_BIT = 7;

    localparam logic [7:0] DTYPE_BURST = 8'h01;
    localparam logic [7:0] DTYPE_STX   = 8'h02;
    localparam logic [7:0] DTYPE_ACK   = 8'h06;

    localparam logic [1:0] FTYPE_UNKNOWN = 2'd0;
    localparam logic [1:0] FTYPE_BURST   = 2'd1;
    localparam logic [1:0] FTYPE_STX     = 2'd2;
    localparam logic [1:0] FTYPE_ACK     = 2'd3;

    localparam logic [1:0] CFG_PREAMBLE = 2'd0;
    localparam logic [1:0] CFG_START    = 2'd1;
    localparam logic [1:0] CFG_POLL     = 2'd2;
    localparam logic [1:0] CFG_UNIQUE   = 2'd3;

    typedef struct packed {
        logic [4:0]         preamble_count;
        logic [1:0]         start_count;
        logic [5:0]         poll_address;
        logic [UADDR_W-1:0] uid_address;
    } hfr_cfg_t;

    // results caused by one byte: optional payload, then optional status
    typedef struct packed {
        logic       pay_v;
        logic [7:0] pay_byte;
        logic       stat_v;
        logic [3:0] status;
        logic [7:0] command;
        logic [7:0] byte_count;
        logic [1:0] delim_type;
        logic       long_address;
    } hfr_entry_t;

endpackage

// ===== hw/rtl/hfr_front.sv =====
// Front end: accepts bytes, runs the frame stage tracker and emits one queue
// entry per byte that causes results. Depends on hfr_pkg.
module hfr_front
    import hfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hfr_cfg_t   cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       buffer_end,
    input  logic       push_ready,
    output logic       push,
    output hfr_entry_t push_entry
);

    hfr_stage_t stage_reg, stage_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] xor_reg, xor_next;
    logic [3:0] perr_reg, perr_next;
    logic       long_reg, long_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] hcnt_reg, hcnt_next;
    logic [1:0] type_reg, type_next;

    logic       accept;
    logic       pay_v;
    logic       fin_v;
    logic [3:0] fin_st;
    logic       addr_ok;
    logic [7:0] addr_len;
    logic [7:0] uaddr_byte;
    logic [7:0] lo_bits;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (pay_v || fin_v);

    // selected byte of the long address for the current position
    always_comb
    begin
        uaddr_byte = 8'h00;
        for (int k = 1; k < LONG_ADDR_BYTES; k++)
        begin
            if (cnt_reg == 8'(k))
                uaddr_byte = cfg.uid_address[8*(LONG_ADDR_BYTES-1-k) +: 8];
        end
    end

    always_comb
    begin
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        perr_next  = perr_reg;
        long_next  = long_reg;
        cmd_next   = cmd_reg;
        hcnt_next  = hcnt_reg;
        type_next  = type_reg;
        pay_v      = 1'b0;
        fin_v      = 1'b0;
        fin_st     = STS_OK;
        addr_ok    = 1'b0;
        addr_len   = 8'd1;
        lo_bits    = rx_byte & DELIM_TYP_MASK;
        push_entry = '0;

        // skip stages that are already complete
        if (perr_next == 4'd0)
        begin
            if (stage_next == STG_PRE && cnt_next >= {3'b000, cfg.preamble_count})
            begin
                stage_next = STG_START;
                cnt_next   = 8'd0;
            end
            if (stage_next == STG_START && cnt_next >= {6'b000000, cfg.start_count})
            begin
                stage_next = STG_DELIM;
                cnt_next   = 8'd0;
            end
            if (stage_next == STG_DATA && cnt_next >= hcnt_next)
            begin
                stage_next = STG_CHECK;
                cnt_next   = 8'd0;
            end
        end

        case (stage_next)
            STG_PRE, STG_START:
            begin
                if (rx_byte != SYNC_BYTE && perr_next == 4'd0)
                    perr_next = (stage_next == STG_PRE) ? STS_PRE_VALUE : STS_START_VALUE;
                cnt_next = cnt_next + 8'd1;
                if (cnt_next >= ((stage_next == STG_PRE) ? {3'b000, cfg.preamble_count}
                                                         : {6'b000000, cfg.start_count}))
                begin
                    if (perr_next != 4'd0)
                    begin
                        fin_v  = 1'b1;
                        fin_st = perr_next;
                    end
                    else
                    begin
                        stage_next = (stage_next == STG_PRE) ? STG_START : STG_DELIM;
                        cnt_next   = 8'd0;
                    end
                end
            end
            STG_DELIM:
            begin
                xor_next = xor_next ^ rx_byte;
                if (lo_bits == DTYPE_BURST)
                    type_next = FTYPE_BURST;
                else if (lo_bits == DTYPE_STX)
                    type_next = FTYPE_STX;
                else if (lo_bits == DTYPE_ACK)
                    type_next = FTYPE_ACK;
                else
                    type_next = FTYPE_UNKNOWN;
                long_next = rx_byte[DELIM_LONG_BIT];
                if ((rx_byte & DELIM_EXP_MASK) != 8'h00)
                begin
                    fin_v  = 1'b1;
                    fin_st = STS_EXPANSION;
                end
                else if ((rx_byte & DELIM_MOD_MASK) != 8'h00)
                begin
                    fin_v  = 1'b1;
                    fin_st = STS_NOT_FSK;
                end
                else
                begin
                    stage_next = STG_ADDR;
                    cnt_next   = 8'd0;
                end
            end
            STG_ADDR:
            begin
                addr_len = long_next ? 8'(LONG_ADDR_BYTES) : 8'd1;
                xor_next = xor_next ^ rx_byte;
                if (!long_next)
                    addr_ok = (rx_byte[5:0] == cfg.poll_address);
                else if (cnt_next == 8'd0)
                    addr_ok = (rx_byte[5:0] == cfg.uid_address[UADDR_W-1 -: 6]);
                else if (cnt_next < 8'(LONG_ADDR_BYTES))
                    addr_ok = (rx_byte == uaddr_byte);
                else
                    addr_ok = 1'b0;
                if (!addr_ok && perr_next == 4'd0)
                    perr_next = STS_ADDR_MISM;
                cnt_next = cnt_next + 8'd1;
                if (cnt_next >= addr_len)
                begin
                    if (perr_next != 4'd0)
                    begin
                        fin_v  = 1'b1;
                        fin_st = perr_next;
                    end
                    else
                    begin
                        stage_next = STG_CMD;
                        cnt_next   = 8'd0;
                    end
                end
            end
            STG_CMD:
            begin
                xor_next = xor_next ^ rx_byte;
                cmd_next = rx_byte;
                if (!long_next && rx_byte != 8'h00)
                begin
                    fin_v  = 1'b1;
                    fin_st = STS_ADDR_MISM;
                end
                else
                begin
                    stage_next = STG_COUNT;
                    cnt_next   = 8'd0;
                end
            end
            STG_COUNT:
            begin
                xor_next   = xor_next ^ rx_byte;
                hcnt_next  = rx_byte;
                stage_next = STG_DATA;
                cnt_next   = 8'd0;
            end
            STG_DATA:
            begin
                xor_next = xor_next ^ rx_byte;
                pay_v    = 1'b1;
                cnt_next = cnt_next + 8'd1;
            end
            STG_CHECK:
            begin
                fin_v  = 1'b1;
                fin_st = (rx_byte == xor_next) ? STS_OK : STS_BAD_CHECK;
            end
            default:
            begin
            end
        endcase

        if (fin_v)
        begin
            stage_next = STG_DRAIN;
            cnt_next   = 8'd0;
            perr_next  = 4'd0;
        end

        if (perr_next == 4'd0)
        begin
            if (stage_next == STG_PRE && cnt_next >= {3'b000, cfg.preamble_count})
            begin
                stage_next = STG_START;
                cnt_next   = 8'd0;
            end
            if (stage_next == STG_START && cnt_next >= {6'b000000, cfg.start_count})
            begin
                stage_next = STG_DELIM;
                cnt_next   = 8'd0;
            end
            if (stage_next == STG_DATA && cnt_next >= hcnt_next)
            begin
                stage_next = STG_CHECK;
                cnt_next   = 8'd0;
            end
        end

        // early end: report the short code of the stage in progress
        if (buffer_end && stage_next != STG_DRAIN)
        begin
            fin_v = 1'b1;
            case (stage_next)
                STG_PRE:   fin_st = STS_PRE_SHORT;
                STG_START: fin_st = STS_START_SHORT;
                STG_DELIM: fin_st = STS_NO_DELIM;
                STG_ADDR:  fin_st = long_next ? STS_LADDR_SHORT : STS_SADDR_SHORT;
                STG_CMD:   fin_st = STS_NO_CMD;
                STG_COUNT: fin_st = STS_NO_COUNT;
                STG_DATA:  fin_st = STS_DATA_SHORT;
                default:   fin_st = STS_NO_CHECK;
            endcase
        end

        push_entry.pay_v        = pay_v;
        push_entry.pay_byte     = rx_byte;
        push_entry.stat_v       = fin_v;
        push_entry.status       = fin_st;
        push_entry.command      = cmd_next;
        push_entry.byte_count   = hcnt_next;
        push_entry.delim_type   = type_next;
        push_entry.long_address = long_next;

        if (buffer_end)
        begin
            stage_next = STG_PRE;
            cnt_next   = 8'd0;
            xor_next   = 8'd0;
            perr_next  = 4'd0;
            long_next  = 1'b0;
            cmd_next   = 8'd0;
            hcnt_next  = 8'd0;
            type_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= STG_PRE;
            cnt_reg   <= 8'd0;
            xor_reg   <= 8'd0;
            perr_reg  <= 4'd0;
            long_reg  <= 1'b0;
            cmd_reg   <= 8'd0;
            hcnt_reg  <= 8'd0;
            type_reg  <= 2'd0;
        end
        else if (accept)
        begin
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            perr_reg  <= perr_next;
            long_reg  <= long_next;
            cmd_reg   <= cmd_next;
            hcnt_reg  <= hcnt_next;
            type_reg  <= type_next;
        end
    end

`ifndef SYNTHESIS
    a_drain_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg == STG_DRAIN) |-> (perr_reg == 4'd0 && cnt_reg == 8'd0))
        else $error("drain stage with pending error or count");
    a_push_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && buffer_end && stage_reg != STG_DRAIN) |-> (push && push_entry.stat_v))
        else $error("buffer end in an open frame gave no status");
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && buffer_end) |=> (stage_reg == STG_PRE && xor_reg == 8'd0))
        else $error("frame state not cleared after buffer end");
`endif

endmodule

// ===== hw/rtl/hfr_queue.sv =====
// Short result-entry queue between the front end and the output stage.
// Depends on hfr_pkg.
module hfr_queue
    import hfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  hfr_entry_t push_entry,
    output logic       push_ready,
    input  logic       pop,
    output logic       head_valid,
    output hfr_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hfr_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !pop) |=> (head_valid && $stable(head)))
        else $error("queue head changed without pop");
`endif

endmodule

// ===== hw/rtl/hfr_back.sv =====
// Output stage: expands a queue entry into a payload item and/or a status
// item and drives the result channel. Depends on hfr_pkg.
module hfr_back
    import hfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  hfr_entry_t head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] payload_byte,
    output logic [3:0] status,
    output logic [7:0] command,
    output logic [7:0] byte_count,
    output logic [1:0] delim_type,
    output logic       long_address,
    output logic       last
);

    logic phase_reg, phase_next;
    logic is_pay;
    logic out_acc;

    assign is_pay       = head.pay_v && !phase_reg;
    assign out_valid    = head_valid;
    assign out_acc      = out_valid && out_ready;
    assign kind         = !is_pay;
    assign payload_byte = is_pay ? head.pay_byte : 8'h00;
    assign status       = is_pay ? STS_OK : head.status;
    assign command      = head.command;
    assign byte_count   = head.byte_count;
    assign delim_type   = head.delim_type;
    assign long_address = head.long_address;
    assign last         = !(is_pay && head.stat_v);
    assign pop          = out_acc && last;

    always_comb
    begin
        phase_next = phase_reg;
        if (out_acc)
            phase_next = !last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 1'b0;
        else
            phase_reg <= phase_next;
    end

`ifndef SYNTHESIS
    a_phase_entry: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head_valid && head.pay_v && head.stat_v))
        else $error("second phase on an entry without two results");
    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head.pay_v || head.stat_v))
        else $error("queue entry carries no result");
    a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !last) |=> (out_valid && kind && last))
        else $error("payload item not followed by its status item");
`endif

endmodule

// ===== hw/rtl/hart_frame_receiver_core.sv =====
// Top level of the frame receiver: configuration registers, front end,
// result queue and output stage. Depends on hfr_pkg, hfr_front, hfr_queue, hfr_back.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | rx_byte, buffer_end
//  out     | out_valid / out_ready| kind, payload_byte, status, command,
//          |                      | byte_count, delim_type, long_address, last
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte is accepted per cycle; its results reach the queue on the same edge.
// A byte ending a buffer inside the data field yields two items from its queue entry,
// a payload item and then a status item; otherwise each entry yields one item.
// Input stalls only when the QUEUE_DEPTH-entry queue is full. cfg_ready is always high.
// Reset (rst_n low, asynchronous) empties the queue and loads register defaults.
module hart_frame_receiver_core
    import hfr_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               buffer_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [7:0]         payload_byte,
    output logic [3:0]         status,
    output logic [7:0]         command,
    output logic [7:0]         byte_count,
    output logic [1:0]         delim_type,
    output logic               long_address,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [UADDR_W-1:0] cfg_data
);

    hfr_cfg_t   cfg_reg, cfg_next;
    logic       push;
    logic       push_ready;
    hfr_entry_t push_entry;
    logic       pop;
    logic       head_valid;
    hfr_entry_t head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PREAMBLE: cfg_next.preamble_count = cfg_data[4:0];
                CFG_START:    cfg_next.start_count    = cfg_data[1:0];
                CFG_POLL:     cfg_next.poll_address   = cfg_data[5:0];
                CFG_UNIQUE:   cfg_next.uid_address    = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_count <= 5'd5;
            cfg_reg.start_count    <= 2'd1;
            cfg_reg.poll_address   <= 6'd0;
            cfg_reg.uid_address    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .buffer_end (buffer_end),
        .push_ready (push_ready),
        .push       (push),
        .push_entry (push_entry)
    );

    hfr_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    hfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .status       (status),
        .command      (command),
        .byte_count   (byte_count),
        .delim_type   (delim_type),
        .long_address (long_address),
        .last         (last)
    );

endmodule

// ===== bench/hart_frame_receiver_core_test.sv =====
// Self-checking bench for hart_frame_receiver_core: a directed table followed by random
// buffers under several register settings, all checked against a behavioral frame parser.
// Depends on hfr_pkg and the hart_frame_receiver_core RTL.
module hart_frame_receiver_core_test;
    import hfr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 230;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic       kind;
        logic [7:0] pay;
        logic [3:0] sts;
        logic [7:0] cmd;
        logic [7:0] bcnt;
        logic [1:0] ftype;
        logic       lng;
        logic       last;
    } frame_result_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       fin;
        logic       typed;
        logic [3:0] sts;
    } directed_row_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       fin;
    } rx_item_t;

    localparam directed_row_t DIRECTED_ROWS [25] = '{
        // short frame, zero start bytes, one data byte, trailing byte ignored
        '{8'hFF, 1'b0, 1'b0, STS_OK},
        '{8'hFF, 1'b0, 1'b0, STS_OK},
        '{8'h02, 1'b0, 1'b0, STS_OK},
        '{8'h15, 1'b0, 1'b0, STS_OK},
        '{8'h00, 1'b0, 1'b0, STS_OK},
        '{8'h01, 1'b0, 1'b0, STS_OK},
        '{8'hAB, 1'b0, 1'b0, STS_OK},
        '{8'hBD, 1'b0, 1'b1, STS_OK},
        '{8'h00, 1'b1, 1'b0, STS_OK},
        // early end wins over a bad preamble byte
        '{8'h00, 1'b1, 1'b1, STS_PRE_SHORT},
        '{8'h00, 1'b0, 1'b0, STS_OK},
        '{8'hFF, 1'b1, 1'b1, STS_PRE_VALUE},
        // expansion checked before modulation
        '{8'hFF, 1'b0, 1'b0, STS_OK},
        '{8'hFF, 1'b0, 1'b0, STS_OK},
        '{8'h78, 1'b1, 1'b1, STS_EXPANSION},
        '{8'hFF, 1'b0, 1'b0, STS_OK},
        '{8'hFF, 1'b0, 1'b0, STS_OK},
        '{8'h18, 1'b1, 1'b1, STS_NOT_FSK},
        // buffer ends inside the data: payload item then status item
        '{8'hFF, 1'b0, 1'b0, STS_OK},
        '{8'hFF, 1'b0, 1'b0, STS_OK},
        '{8'h02, 1'b0, 1'b0, STS_OK},
        '{8'h15, 1'b0, 1'b0, STS_OK},
        '{8'h00, 1'b0, 1'b0, STS_OK},
        '{8'h03, 1'b0, 1'b0, STS_OK},
        '{8'h11, 1'b1, 1'b1, STS_DATA_SHORT}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte = 8'h00;
    logic               buffer_end = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               kind;
    logic [7:0]         payload_byte;
    logic [3:0]         status;
    logic [7:0]         command;
    logic [7:0]         byte_count;
    logic [1:0]         delim_type;
    logic               long_address;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = CFG_PREAMBLE;
    logic [UADDR_W-1:0] cfg_data = '0;

    hart_frame_receiver_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .buffer_end   (buffer_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .status       (status),
        .command      (command),
        .byte_count   (byte_count),
        .delim_type   (delim_type),
        .long_address (long_address),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // register mirror
    logic [4:0]         cfg_preamble = 5'd5;
    logic [1:0]         cfg_start = 2'd1;
    logic [5:0]         cfg_poll = 6'd0;
    logic [UADDR_W-1:0] cfg_unique = '0;

    // frame parser state
    hfr_stage_t         fr_stage = STG_PRE;
    logic [7:0]         fr_count = 8'd0;
    logic [7:0]         fr_xor = 8'd0;
    logic [3:0]         fr_err = STS_OK;
    logic               fr_long = 1'b0;
    logic [7:0]         fr_cmd = 8'd0;
    logic [7:0]         fr_bcnt = 8'd0;
    logic [1:0]         fr_type = FTYPE_UNKNOWN;

    frame_result_t      byte_results [2];
    int                 byte_result_n;
    frame_result_t      predicted_results [$];
    rx_item_t           byte_plan [$];

    int                 send_idle = 0;
    int                 recv_idle = 0;
    logic               pressure_go = 1'b0;
    logic               hold_off = 1'b0;
    int                 cycle_count = 0;
    int                 mismatches = 0;
    int                 bytes_sent = 0;
    int                 buffers_sent = 0;
    int                 payload_items = 0;
    int                 status_items = 0;
    int                 settings_used = 0;
    logic [15:0]        codes_seen = '0;
    frame_result_t      want, seen;

    task automatic clear_frame_state;
        fr_stage = STG_PRE;
        fr_count = 8'd0;
        fr_xor   = 8'd0;
        fr_err   = STS_OK;
        fr_long  = 1'b0;
        fr_cmd   = 8'd0;
        fr_bcnt  = 8'd0;
        fr_type  = FTYPE_UNKNOWN;
    endtask

    task automatic skip_empty_stages;
        if (fr_err == STS_OK)
        begin
            if (fr_stage == STG_PRE && fr_count >= {3'b000, cfg_preamble})
            begin
                fr_stage = STG_START;
                fr_count = 8'd0;
            end
            if (fr_stage == STG_START && fr_count >= {6'b000000, cfg_start})
            begin
                fr_stage = STG_DELIM;
                fr_count = 8'd0;
            end
            if (fr_stage == STG_DATA && fr_count >= fr_bcnt)
            begin
                fr_stage = STG_CHECK;
                fr_count = 8'd0;
            end
        end
    endtask

    task automatic add_result(input logic k, input logic [7:0] pay, input logic [3:0] sts);
        byte_results[byte_result_n] = '{k, pay, sts, fr_cmd, fr_bcnt, fr_type, fr_long, 1'b0};
        byte_result_n++;
    endtask

    task automatic close_frame(input logic [3:0] sts);
        add_result(1'b1, 8'h00, sts);
        fr_stage = STG_DRAIN;
        fr_count = 8'd0;
        fr_err   = STS_OK;
    endtask

    task automatic predict_frame_byte(input logic [7:0] b, input logic fin);
        logic               ok;
        logic [UADDR_W-1:0] shifted;
        logic [3:0]         short_sts;
        byte_result_n = 0;
        skip_empty_stages();
        case (fr_stage)
            STG_PRE, STG_START:
            begin
                if (b != SYNC_BYTE && fr_err == STS_OK)
                    fr_err = (fr_stage == STG_PRE) ? STS_PRE_VALUE : STS_START_VALUE;
                fr_count++;
                if (fr_count >= ((fr_stage == STG_PRE) ? {3'b000, cfg_preamble}
                                                       : {6'b000000, cfg_start}))
                begin
                    if (fr_err != STS_OK)
                        close_frame(fr_err);
                    else
                    begin
                        fr_stage = (fr_stage == STG_PRE) ? STG_START : STG_DELIM;
                        fr_count = 8'd0;
                    end
                end
            end
            STG_DELIM:
            begin
                fr_xor ^= b;
                if ((b & DELIM_TYP_MASK) == DTYPE_BURST)
                    fr_type = FTYPE_BURST;
                else if ((b & DELIM_TYP_MASK) == DTYPE_STX)
                    fr_type = FTYPE_STX;
                else if ((b & DELIM_TYP_MASK) == DTYPE_ACK)
                    fr_type = FTYPE_ACK;
                else
                    fr_type = FTYPE_UNKNOWN;
                fr_long = b[DELIM_LONG_BIT];
                if ((b & DELIM_EXP_MASK) != 8'h00)
                    close_frame(STS_EXPANSION);
                else if ((b & DELIM_MOD_MASK) != 8'h00)
                    close_frame(STS_NOT_FSK);
                else
                begin
                    fr_stage = STG_ADDR;
                    fr_count = 8'd0;
                end
            end
            STG_ADDR:
            begin
                fr_xor ^= b;
                if (!fr_long)
                    ok = (b[5:0] == cfg_poll);
                else if (fr_count == 8'd0)
                    ok = (b[5:0] == cfg_unique[UADDR_W-1 -: 6]);
                else if (fr_count < 8'(LONG_ADDR_BYTES))
                begin
                    shifted = cfg_unique >> (8 * (LONG_ADDR_BYTES - 1 - fr_count));
                    ok = (b == shifted[7:0]);
                end
                else
                    ok = 1'b0;
                if (!ok && fr_err == STS_OK)
                    fr_err = STS_ADDR_MISM;
                fr_count++;
                if (fr_count >= (fr_long ? 8'(LONG_ADDR_BYTES) : 8'd1))
                begin
                    if (fr_err != STS_OK)
                        close_frame(fr_err);
                    else
                    begin
                        fr_stage = STG_CMD;
                        fr_count = 8'd0;
                    end
                end
            end
            STG_CMD:
            begin
                fr_xor ^= b;
                fr_cmd = b;
                if (!fr_long && b != 8'h00)
                    close_frame(STS_ADDR_MISM);
                else
                begin
                    fr_stage = STG_COUNT;
                    fr_count = 8'd0;
                end
            end
            STG_COUNT:
            begin
                fr_xor ^= b;
                fr_bcnt = b;
                fr_stage = STG_DATA;
                fr_count = 8'd0;
            end
            STG_DATA:
            begin
                fr_xor ^= b;
                add_result(1'b0, b, STS_OK);
                fr_count++;
            end
            STG_CHECK:
                close_frame((b == fr_xor) ? STS_OK : STS_BAD_CHECK);
            default:
            begin
            end
        endcase
        skip_empty_stages();
        if (fin)
        begin
            if (fr_stage != STG_DRAIN)
            begin
                case (fr_stage)
                    STG_PRE:   short_sts = STS_PRE_SHORT;
                    STG_START: short_sts = STS_START_SHORT;
                    STG_DELIM: short_sts = STS_NO_DELIM;
                    STG_ADDR:  short_sts = fr_long ? STS_LADDR_SHORT : STS_SADDR_SHORT;
                    STG_CMD:   short_sts = STS_NO_CMD;
                    STG_COUNT: short_sts = STS_NO_COUNT;
                    STG_DATA:  short_sts = STS_DATA_SHORT;
                    default:   short_sts = STS_NO_CHECK;
                endcase
                close_frame(short_sts);
            end
            clear_frame_state();
        end
        if (byte_result_n > 0)
            byte_results[byte_result_n - 1].last = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input logic [3:0] sts);
        logic found;
        if ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
        end
        in_valid   <= 1'b1;
        rx_byte    <= b;
        buffer_end <= fin;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
        if (fin)
            buffers_sent++;
        predict_frame_byte(b, fin);
        if (typed)
        begin
            found = 1'b0;
            for (int k = 0; k < byte_result_n; k++)
            begin
                if (byte_results[k].kind)
                begin
                    byte_results[k].sts = sts;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                $display("%0t: status %0d expected from table, none predicted", $time, sts);
                mismatches++;
            end
        end
        for (int k = 0; k < byte_result_n; k++)
            predicted_results.push_back(byte_results[k]);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [UADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_PREAMBLE: cfg_preamble = data[4:0];
            CFG_START:    cfg_start    = data[1:0];
            CFG_POLL:     cfg_poll     = data[5:0];
            default:      cfg_unique   = data;
        endcase
    endtask

    task automatic set_config(input int pre, input int start, input int poll,
                              input logic [UADDR_W-1:0] uniq);
        write_reg(CFG_PREAMBLE, UADDR_W'(pre));
        write_reg(CFG_START, UADDR_W'(start));
        write_reg(CFG_POLL, UADDR_W'(poll));
        write_reg(CFG_UNIQUE, uniq);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_idle;
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one random buffer: mostly well-formed frames, some noise, mutated or truncated
    task automatic plan_buffer;
        logic [7:0] fb [$];
        logic [7:0] x;
        logic       lng;
        int         hdr;
        int         n;
        int         sel;
        sel = $urandom_range(0, 99);
        if (sel < 12)
        begin
            n = $urandom_range(1, 12);
            repeat (n) fb.push_back(8'($urandom));
        end
        else
        begin
            hdr = cfg_preamble + cfg_start;
            repeat (hdr) fb.push_back(SYNC_BYTE);
            lng = 1'($urandom);
            case ($urandom_range(0, 3))
                0:       x = DTYPE_BURST;
                1:       x = DTYPE_STX;
                2:       x = DTYPE_ACK;
                default: x = 8'($urandom_range(0, 7));
            endcase
            x[DELIM_LONG_BIT] = lng;
            if ($urandom_range(0, 19) == 0)
                x = 8'($urandom);
            fb.push_back(x);
            if (!x[DELIM_LONG_BIT])
            begin
                fb.push_back({2'($urandom), cfg_poll});
                fb.push_back(8'h00);
            end
            else
            begin
                fb.push_back({2'($urandom), cfg_unique[UADDR_W-1 -: 6]});
                for (int i = LONG_ADDR_BYTES - 2; i >= 0; i--)
                    fb.push_back(cfg_unique[8 * i +: 8]);
                fb.push_back(8'($urandom));
            end
            n = ($urandom_range(0, 29) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
            fb.push_back(8'(n));
            repeat (n) fb.push_back(8'($urandom));
            x = 8'h00;
            for (int i = hdr; i < fb.size(); i++)
                x ^= fb[i];
            if ($urandom_range(0, 9) == 0)
                x ^= 8'(1 << $urandom_range(0, 7));
            fb.push_back(x);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
            sel = $urandom_range(0, 99);
            if (sel < 10)
                fb[$urandom_range(0, fb.size() - 1)] = 8'($urandom);
            else if (sel < 22)
            begin
                n = $urandom_range(1, fb.size());
                while (fb.size() > n)
                    void'(fb.pop_back());
            end
        end
        for (int i = 0; i < fb.size(); i++)
            byte_plan.push_back('{fb[i], i == fb.size() - 1});
    endtask

    task automatic report_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= hold_off ? 1'b0 : ($urandom_range(0, 99) >= recv_idle);
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{kind, payload_byte, status, command, byte_count, delim_type,
                     long_address, last};
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, actual %h", $time, seen);
                mismatches++;
            end
            else
            begin
                want = predicted_results.pop_front();
                report_field("kind", 8'(want.kind), 8'(seen.kind));
                report_field("payload_byte", want.pay, seen.pay);
                report_field("status", 8'(want.sts), 8'(seen.sts));
                report_field("command", want.cmd, seen.cmd);
                report_field("byte_count", want.bcnt, seen.bcnt);
                report_field("delim_type", 8'(want.ftype), 8'(seen.ftype));
                report_field("long_address", 8'(want.lng), 8'(seen.lng));
                report_field("last", 8'(want.last), 8'(seen.last));
            end
            if (kind)
            begin
                status_items++;
                codes_seen[status] = 1'b1;
            end
            else
                payload_items++;
        end
    end

    // receiver hold-off so the result queue fills and input stalls
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("hart_frame_receiver_core regression: fail");
        $finish;
    end

    initial
    begin
        rx_item_t item;
        int       sent;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 22;
        recv_idle = 66;
        set_config(2, 0, 6'h15, 38'h2A_1234_5678);
        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].sts);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_config(2, 0, 0, '0);
                1: set_config(20, 3, 63, {UADDR_W{1'b1}});
                2: set_config($urandom_range(2, 6), $urandom_range(0, 3), $urandom_range(0, 63),
                              UADDR_W'({$urandom, $urandom}));
                3: set_config(5, 1, $urandom_range(0, 63), UADDR_W'({$urandom, $urandom}));
                4: set_config(3, 2, $urandom_range(0, 63), UADDR_W'({$urandom, $urandom}));
                default: set_config($urandom_range(2, 20), $urandom_range(0, 3),
                                    $urandom_range(0, 63), UADDR_W'({$urandom, $urandom}));
            endcase
            if (ph < 2)
            begin
                send_idle = 22;
                recv_idle = 66;
            end
            else if (ph < 4)
            begin
                send_idle = 66;
                recv_idle = 22;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (ph == 4)
                pressure_go = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                plan_buffer();
                while (byte_plan.size() != 0)
                begin
                    item = byte_plan.pop_front();
                    send_byte(item.rx, item.fin, 1'b0, STS_OK);
                    sent++;
                end
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        $display("sent %0d bytes in %0d buffers over %0d register settings", bytes_sent,
                 buffers_sent, settings_used);
        $display("checked %0d payload and %0d status items, %0d distinct status codes",
                 payload_items, status_items, $countones(codes_seen));
        if (mismatches == 0)
            $display("hart_frame_receiver_core regression: pass");
        else
            $display("hart_frame_receiver_core regression: fail");
        $finish;
    end

endmodule
